// File: rtl/i2c_eeprom_pkg.sv
package i2c_eeprom_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACTIVE,
        ST_STOPPED
    } seq_state_t;

    typedef enum logic [2:0] {
        OP_START,
        OP_WBYTE,
        OP_ACK,
        OP_RBYTE,
        OP_STOP
    } op_kind_t;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] CFG_CHIP_SELECT = 2'd0;
    localparam logic [1:0] CFG_PHASE_TICKS = 2'd1;
    localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd2;

    localparam logic [7:0] CTRL_WRITE = 8'hA0;
    localparam logic [7:0] CTRL_READ  = 8'hA1;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    localparam logic [3:0] SEG_CTRL_WRITE = 4'd1;
    localparam logic [3:0] SEG_ADDRESS    = 4'd3;
    localparam logic [3:0] SEG_CTRL_READ  = 4'd6;

    function automatic op_kind_t seg_kind(input logic is_read, input logic [3:0] seg);
        op_kind_t kind;
        kind = OP_STOP;
        if (is_read)
        begin
            case (seg)
                4'd0, 4'd5:       kind = OP_START;
                4'd1, 4'd3, 4'd6: kind = OP_WBYTE;
                4'd2, 4'd4, 4'd7: kind = OP_ACK;
                4'd8:             kind = OP_RBYTE;
                default:          kind = OP_STOP;
            endcase
        end
        else
        begin
            case (seg)
                4'd0:             kind = OP_START;
                4'd1, 4'd3, 4'd5: kind = OP_WBYTE;
                4'd2, 4'd4, 4'd6: kind = OP_ACK;
                default:          kind = OP_STOP;
            endcase
        end
        return kind;
    endfunction

endpackage

// File: rtl/i2c_eeprom_byte_access_master.sv
// i2c_eeprom_byte_access_master: bit-level i2c master for a serial eeprom
//
// input channel (in_valid / in_stall): one beat is one tick of the bit timer,
// carrying req_type, mem_address, write_data and the sampled sda_in level.
// req_type write or read starts a transaction when idle; otherwise ignored.
// output channel (out_valid / out_stall): exactly one result beat per input
// beat, with the pin levels, busy/done flags, last read byte and ack status.
// configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): writes
// chip_select, phase_ticks, ack_timeout; always ready, write only while idle.
// the result of a beat is registered and appears in the cycle after the beat is taken.
// throughput: one beat per cycle; the whole tick is evaluated combinationally
// between the sequencer state registers and the result register.
// when out_stall holds a waiting result, in_stall rises and the sequencer
// stops; the result register parts the two sides so no cycle is lost.
// reset: sequencer idle, scl and sda released high, config at defaults
// (chip_select 0, phase_ticks 1, ack_timeout 250), no result pending.
module i2c_eeprom_byte_access_master
    import i2c_eeprom_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] req_type,
    input  logic [7:0] mem_address,
    input  logic [7:0] write_data,
    input  logic       sda_in,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_out,
    output logic       sda_out,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] read_data,
    output logic       ack_missing,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    logic [2:0]  chip_select_reg;
    logic [15:0] phase_ticks_reg;
    logic [7:0]  ack_timeout_reg;

    seq_state_t  state_reg, state_next;
    logic [3:0]  seg_reg, seg_next;
    logic [2:0]  sub_reg, sub_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] hold_reg, hold_next;
    logic [7:0]  poll_reg, poll_next;
    logic        is_read_reg, is_read_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  rx_reg, rx_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        fail_reg, fail_next;
    logic        done_next;

    logic        out_valid_reg, out_valid_next;
    logic        scl_out_reg, sda_out_reg, busy_out_reg, done_out_reg, fail_out_reg;
    logic [7:0]  rx_out_reg;

    logic        accept_in;
    logic [15:0] hold_load;
    op_kind_t    cur_kind;
    op_kind_t    enter_kind;
    logic [3:0]  seg_inc;
    logic [7:0]  enter_byte;
    logic [7:0]  shifted_in;
    logic        do_enter;

    assign in_stall  = out_valid_reg & out_stall;
    assign accept_in = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    assign hold_load  = (phase_ticks_reg == 16'd0) ? 16'd0 : phase_ticks_reg - 16'd1;
    assign cur_kind   = seg_kind(is_read_reg, seg_reg);
    assign seg_inc    = seg_reg + 4'd1;
    assign enter_kind = seg_kind(is_read_reg, seg_inc);
    assign shifted_in = {shift_reg[6:0], sda_in};

    always_comb
    begin
        case (seg_inc)
            SEG_CTRL_WRITE: enter_byte = CTRL_WRITE | {4'd0, chip_select_reg, 1'b0};
            SEG_ADDRESS:    enter_byte = addr_reg;
            SEG_CTRL_READ:  enter_byte = CTRL_READ | {4'd0, chip_select_reg, 1'b0};
            default:        enter_byte = data_reg;
        endcase
    end

    // one timer tick of the sequencer
    always_comb
    begin
        state_next   = state_reg;
        seg_next     = seg_reg;
        sub_next     = sub_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        hold_next    = hold_reg;
        poll_next    = poll_reg;
        is_read_next = is_read_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        rx_next      = rx_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        fail_next    = fail_reg;
        done_next    = 1'b0;
        do_enter     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_type == REQ_WRITE || req_type == REQ_READ)
                begin
                    // start segment, first pin setting happens in this tick
                    state_next   = ST_ACTIVE;
                    is_read_next = (req_type == REQ_READ);
                    addr_next    = mem_address;
                    data_next    = write_data;
                    fail_next    = 1'b0;
                    poll_next    = 8'd0;
                    bit_next     = 3'd0;
                    seg_next     = 4'd0;
                    sub_next     = 3'd1;
                    sda_next     = 1'b1;
                    hold_next    = hold_load;
                end
            end
            ST_STOPPED:
            begin
                if (hold_reg != 16'd0)
                begin
                    hold_next = hold_reg - 16'd1;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_ACTIVE:
            begin
                if (hold_reg != 16'd0)
                begin
                    hold_next = hold_reg - 16'd1;
                end
                else
                begin
                    case (cur_kind)
                        OP_START, OP_STOP:
                        begin
                            hold_next = hold_load;
                            case (sub_reg)
                                3'd0:
                                begin
                                    sda_next = (cur_kind == OP_START);
                                    sub_next = 3'd1;
                                end
                                3'd1:
                                begin
                                    scl_next = 1'b1;
                                    sub_next = 3'd2;
                                end
                                default:
                                begin
                                    sda_next = (cur_kind != OP_START);
                                    if (cur_kind == OP_STOP)
                                    begin
                                        state_next = ST_STOPPED;
                                    end
                                    else
                                    begin
                                        do_enter = 1'b1;
                                    end
                                end
                            endcase
                        end
                        OP_WBYTE:
                        begin
                            hold_next = hold_load;
                            case (sub_reg)
                                3'd0:
                                begin
                                    scl_next = 1'b0;
                                    sub_next = 3'd1;
                                end
                                3'd1:
                                begin
                                    sda_next   = shift_reg[7];
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    sub_next   = 3'd2;
                                end
                                3'd2:
                                begin
                                    scl_next = 1'b1;
                                    if (bit_reg == 3'd7)
                                    begin
                                        bit_next = 3'd0;
                                        sub_next = 3'd3;
                                    end
                                    else
                                    begin
                                        bit_next = bit_reg + 3'd1;
                                        sub_next = 3'd0;
                                    end
                                end
                                3'd3:
                                begin
                                    scl_next = 1'b0;
                                    sub_next = 3'd4;
                                end
                                default:
                                begin
                                    sda_next = 1'b1;
                                    do_enter = 1'b1;
                                end
                            endcase
                        end
                        OP_ACK:
                        begin
                            if (sub_reg == 3'd0)
                            begin
                                scl_next  = 1'b1;
                                hold_next = hold_load;
                                poll_next = 8'd0;
                                sub_next  = 3'd1;
                            end
                            else if (sda_in && poll_reg < ack_timeout_reg)
                            begin
                                poll_next = poll_reg + 8'd1;
                            end
                            else
                            begin
                                if (sda_in)
                                begin
                                    fail_next = 1'b1;
                                end
                                scl_next  = 1'b0;
                                hold_next = hold_load;
                                do_enter  = 1'b1;
                            end
                        end
                        OP_RBYTE:
                        begin
                            hold_next = hold_load;
                            case (sub_reg)
                                3'd0:
                                begin
                                    scl_next = 1'b0;
                                    sub_next = 3'd1;
                                end
                                3'd1:
                                begin
                                    sda_next = 1'b1;
                                    sub_next = 3'd2;
                                end
                                3'd2:
                                begin
                                    scl_next = 1'b1;
                                    sub_next = 3'd3;
                                end
                                default:
                                begin
                                    // sample the bit and drop scl in the same tick
                                    shift_next = shifted_in;
                                    scl_next   = 1'b0;
                                    if (bit_reg == 3'd7)
                                    begin
                                        rx_next  = shifted_in;
                                        do_enter = 1'b1;
                                    end
                                    else
                                    begin
                                        bit_next = bit_reg + 3'd1;
                                        sub_next = 3'd2;
                                    end
                                end
                            endcase
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_enter)
        begin
            seg_next = seg_inc;
            sub_next = 3'd0;
            bit_next = 3'd0;
            if (enter_kind == OP_WBYTE)
            begin
                shift_next = enter_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_select_reg <= 3'd0;
            phase_ticks_reg <= 16'd1;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CHIP_SELECT: chip_select_reg <= cfg_data[2:0];
                CFG_PHASE_TICKS: phase_ticks_reg <= cfg_data;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seg_reg     <= 4'd0;
            sub_reg     <= 3'd0;
            bit_reg     <= 3'd0;
            shift_reg   <= 8'd0;
            hold_reg    <= 16'd0;
            poll_reg    <= 8'd0;
            is_read_reg <= 1'b0;
            addr_reg    <= 8'd0;
            data_reg    <= 8'd0;
            rx_reg      <= 8'd0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            fail_reg    <= 1'b0;
        end
        else if (accept_in)
        begin
            state_reg   <= state_next;
            seg_reg     <= seg_next;
            sub_reg     <= sub_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            hold_reg    <= hold_next;
            poll_reg    <= poll_next;
            is_read_reg <= is_read_next;
            addr_reg    <= addr_next;
            data_reg    <= data_next;
            rx_reg      <= rx_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            fail_reg    <= fail_next;
        end
    end

    assign out_valid_next = accept_in | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            scl_out_reg  <= scl_next;
            sda_out_reg  <= sda_next;
            busy_out_reg <= (state_next != ST_IDLE);
            done_out_reg <= done_next;
            rx_out_reg   <= rx_next;
            fail_out_reg <= fail_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_out     = scl_out_reg;
    assign sda_out     = sda_out_reg;
    assign busy_res    = busy_out_reg;
    assign done_res    = done_out_reg;
    assign read_data   = rx_out_reg;
    assign ack_missing = fail_out_reg;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_out_reg |-> !busy_out_reg)
        else $error("done result while still busy");

    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> hold_reg == 16'd0)
        else $error("hold count pending while idle");

    a_stopped_released: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STOPPED |-> scl_reg && sda_reg)
        else $error("bus not released after stop");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> out_valid_reg)
        else $error("accepted beat produced no result");

    a_seg_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACTIVE |-> (is_read_reg ? seg_reg < 4'd10 : seg_reg < 4'd8))
        else $error("segment beyond program end");
`endif

endmodule

// File: dv/i2c_eeprom_byte_access_master_test.sv
module i2c_eeprom_byte_access_master_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_eeprom_pkg::*;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rdata;
        logic       nack;
    } pins_t;

    typedef enum logic [1:0] {
        RUN_ONCE,
        RUN_TO_IDLE,
        RUN_TO_FINISH
    } run_mode_t;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] addr;
        logic [7:0] data;
        logic       sda;
        run_mode_t  run;
        logic       typed;
        pins_t      want;
    } plan_row_t;

    localparam int SUBS = 5;
    localparam int PLAN_ROWS = 14;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_BEATS = 50;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;
    localparam logic [15:0] PLAN_ACK_TIMEOUT = 16'd5;

    localparam pins_t IDLE_PINS = '{scl: 1'b1, sda: 1'b1, busy: 1'b0, done: 1'b0,
                                    rdata: 8'h00, nack: 1'b0};
    localparam pins_t NACK_FF_PINS = '{scl: 1'b1, sda: 1'b1, busy: 1'b0, done: 1'b0,
                                       rdata: 8'hFF, nack: 1'b1};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] req_type;
    logic [7:0] mem_address;
    logic [7:0] write_data;
    logic       sda_in;
    logic       out_valid;
    logic       out_stall;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_missing;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    // sequencer mirror
    logic [2:0]  sel_pins;
    logic [15:0] hold_ticks;
    logic [7:0]  poll_limit;
    int          seq_pos;
    int          bit_idx;
    logic [7:0]  shifter;
    int          hold_left;
    logic [7:0]  polls;
    logic        reading;
    logic [7:0]  addr_q;
    logic [7:0]  data_q;
    logic [7:0]  rx_byte;
    logic        scl_q;
    logic        sda_q;
    logic        nack_seen;

    pins_t expected_pins[$];
    int    error_count = 0;
    int    beats_checked = 0;
    int    sender_calm = 0;
    bit    paused_mid = 1'b0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{REQ_TICK,   8'h00, 8'h00, 1'b0, RUN_ONCE,      1'b1, IDLE_PINS},
        '{REQ_UNUSED, 8'hFF, 8'hFF, 1'b1, RUN_ONCE,      1'b1, IDLE_PINS},
        '{REQ_WRITE,  8'hFF, 8'h00, 1'b0, RUN_ONCE,      1'b0, '0},
        '{REQ_READ,   8'h00, 8'hFF, 1'b1, RUN_ONCE,      1'b0, '0},
        '{REQ_TICK,   8'h00, 8'h00, 1'b0, RUN_TO_FINISH, 1'b0, '0},
        '{REQ_WRITE,  8'h55, 8'hAA, 1'b0, RUN_ONCE,      1'b0, '0},
        '{REQ_TICK,   8'h00, 8'h00, 1'b0, RUN_ONCE,      1'b1, IDLE_PINS},
        '{REQ_READ,   8'hFF, 8'h00, 1'b1, RUN_TO_IDLE,   1'b0, '0},
        '{REQ_TICK,   8'h00, 8'h00, 1'b1, RUN_ONCE,      1'b1, NACK_FF_PINS},
        '{REQ_WRITE,  8'h00, 8'hFF, 1'b1, RUN_ONCE,      1'b0, '0},
        '{REQ_TICK,   8'h00, 8'h00, 1'b0, RUN_TO_IDLE,   1'b0, '0},
        '{REQ_READ,   8'hAA, 8'h55, 1'b0, RUN_TO_IDLE,   1'b0, '0},
        '{REQ_TICK,   8'h00, 8'h00, 1'b0, RUN_ONCE,      1'b1, IDLE_PINS},
        '{REQ_UNUSED, 8'h00, 8'h00, 1'b0, RUN_ONCE,      1'b1, IDLE_PINS}
    };

    i2c_eeprom_byte_access_master DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .mem_address (mem_address),
        .write_data  (write_data),
        .sda_in      (sda_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scl_out     (scl_out),
        .sda_out     (sda_out),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .read_data   (read_data),
        .ack_missing (ack_missing),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int seg_count();
        return reading ? 10 : 8;
    endfunction

    function automatic op_kind_t op_at(input int seg);
        op_kind_t kind;
        kind = OP_STOP;
        if (seg == 0 || (reading && seg == 5))
            kind = OP_START;
        else if (seg == 1 || seg == 3 || (reading ? seg == 6 : seg == 5))
            kind = OP_WBYTE;
        else if (seg == 2 || seg == 4 || (reading ? seg == 7 : seg == 6))
            kind = OP_ACK;
        else if (reading && seg == 8)
            kind = OP_RBYTE;
        return kind;
    endfunction

    function automatic void set_pos(input int seg, input int sub);
        seq_pos = 1 + seg * SUBS + sub;
    endfunction

    function automatic void restart_hold();
        hold_left = (hold_ticks == 16'd0) ? 0 : hold_ticks - 1;
    endfunction

    function automatic bit enter_seg(input int seg);
        logic [7:0] sel_byte;
        sel_byte = {4'b0000, sel_pins, 1'b0};
        if (seg >= seg_count())
        begin
            seq_pos = 0;
            return 1'b0;
        end
        bit_idx = 0;
        if (op_at(seg) == OP_WBYTE)
        begin
            if (seg == SEG_CTRL_WRITE)
                shifter = CTRL_WRITE | sel_byte;
            else if (seg == SEG_ADDRESS)
                shifter = addr_q;
            else if (seg == SEG_CTRL_READ)
                shifter = CTRL_READ | sel_byte;
            else
                shifter = data_q;
        end
        set_pos(seg, 0);
        return 1'b1;
    endfunction

    // returns 1 when this tick's pin work is over
    function automatic bit micro_step(input logic sda_line);
        int       seg;
        int       sub;
        op_kind_t kind;
        bit       ends;
        seg = (seq_pos - 1) / SUBS;
        sub = (seq_pos - 1) % SUBS;
        kind = op_at(seg);
        ends = 1'b1;
        case (kind)
            OP_START, OP_STOP:
            begin
                if (sub == 0)
                begin
                    sda_q = (kind == OP_START);
                    restart_hold();
                    set_pos(seg, 1);
                end
                else if (sub == 1)
                begin
                    scl_q = 1'b1;
                    restart_hold();
                    set_pos(seg, 2);
                end
                else
                begin
                    sda_q = (kind == OP_STOP);
                    restart_hold();
                    if (!enter_seg(seg + 1))
                        set_pos(seg, 3);
                end
            end
            OP_WBYTE:
            begin
                if (sub == 0)
                begin
                    scl_q = 1'b0;
                    restart_hold();
                    set_pos(seg, 1);
                end
                else if (sub == 1)
                begin
                    sda_q = shifter[7];
                    restart_hold();
                    shifter = {shifter[6:0], 1'b0};
                    set_pos(seg, 2);
                end
                else if (sub == 2)
                begin
                    scl_q = 1'b1;
                    restart_hold();
                    if (bit_idx >= 7)
                    begin
                        bit_idx = 0;
                        set_pos(seg, 3);
                    end
                    else
                    begin
                        bit_idx++;
                        set_pos(seg, 0);
                    end
                end
                else if (sub == 3)
                begin
                    scl_q = 1'b0;
                    restart_hold();
                    set_pos(seg, 4);
                end
                else
                begin
                    sda_q = 1'b1;
                    restart_hold();
                    void'(enter_seg(seg + 1));
                end
            end
            OP_ACK:
            begin
                if (sub == 0)
                begin
                    scl_q = 1'b1;
                    restart_hold();
                    polls = 8'd0;
                    set_pos(seg, 1);
                end
                else if (sub == 1)
                begin
                    if (sda_line == 1'b0)
                    begin
                        set_pos(seg, 2);
                        ends = 1'b0;
                    end
                    else if (polls < poll_limit)
                        polls++;
                    else
                    begin
                        nack_seen = 1'b1;
                        set_pos(seg, 2);
                        ends = 1'b0;
                    end
                end
                else
                begin
                    scl_q = 1'b0;
                    restart_hold();
                    void'(enter_seg(seg + 1));
                end
            end
            default:
            begin
                if (sub == 0)
                begin
                    scl_q = 1'b0;
                    restart_hold();
                    set_pos(seg, 1);
                end
                else if (sub == 1)
                begin
                    sda_q = 1'b1;
                    restart_hold();
                    set_pos(seg, 2);
                end
                else if (sub == 2)
                begin
                    scl_q = 1'b1;
                    restart_hold();
                    set_pos(seg, 3);
                end
                else if (sub == 3)
                begin
                    shifter = {shifter[6:0], sda_line};
                    set_pos(seg, 4);
                    ends = 1'b0;
                end
                else
                begin
                    scl_q = 1'b0;
                    restart_hold();
                    if (bit_idx >= 7)
                    begin
                        rx_byte = shifter;
                        void'(enter_seg(seg + 1));
                    end
                    else
                    begin
                        bit_idx++;
                        set_pos(seg, 2);
                    end
                end
            end
        endcase
        return ends;
    endfunction

    function automatic pins_t advance_sequencer(input logic [1:0] req, input logic [7:0] addr,
                                                input logic [7:0] data, input logic sda_line);
        pins_t res;
        bit    finished;
        bit    run;
        int    guard;
        finished = 1'b0;
        run = 1'b0;
        guard = 0;
        if (seq_pos == 0)
        begin
            if (req == REQ_WRITE || req == REQ_READ)
            begin
                reading = (req == REQ_READ);
                addr_q = addr;
                data_q = data;
                nack_seen = 1'b0;
                hold_left = 0;
                polls = 8'd0;
                void'(enter_seg(0));
                run = 1'b1;
            end
        end
        else if (hold_left > 0)
            hold_left--;
        else if (seq_pos == 1 + (seg_count() - 1) * SUBS + 3)
        begin
            seq_pos = 0;
            finished = 1'b1;
        end
        else
            run = 1'b1;
        while (run && guard < 8 && seq_pos != 0)
        begin
            run = !micro_step(sda_line);
            guard++;
        end
        res.scl = scl_q;
        res.sda = sda_q;
        res.busy = (seq_pos != 0);
        res.done = finished;
        res.rdata = rx_byte;
        res.nack = nack_seen;
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at result beat %0d: %s", beats_checked, msg);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
            flag_error($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    task automatic push_tick(input logic [1:0] req, input logic [7:0] addr,
                             input logic [7:0] data, input logic sda, input bit typed,
                             input pins_t want);
        int    gap;
        pins_t got;
        if (sender_calm > 0)
        begin
            sender_calm--;
            gap = 0;
        end
        else if ($urandom_range(0, 99) < 3)
        begin
            sender_calm = $urandom_range(20, 80);
            gap = 0;
        end
        else
            gap = idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        mem_address <= addr;
        write_data <= data;
        sda_in <= sda;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        got = advance_sequencer(req, addr, data, sda);
        expected_pins.push_back(typed ? want : got);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            CFG_CHIP_SELECT: sel_pins = val[2:0];
            CFG_PHASE_TICKS: hold_ticks = val;
            CFG_ACK_TIMEOUT: poll_limit = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_transfer(input int beat_cap, output int used);
        bit         present;
        int         lead;
        logic [1:0] req;
        logic       sda;
        used = 0;
        present = ($urandom_range(0, 99) >= 15);
        lead = $urandom_range(0, 3);
        repeat (lead)
        begin
            push_tick($urandom_range(0, 1) ? REQ_TICK : REQ_UNUSED, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
            used++;
        end
        push_tick($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
        used++;
        while (seq_pos != 0 && used < beat_cap)
        begin
            if (op_at((seq_pos - 1) / SUBS) == OP_ACK)
                sda = present ? ($urandom_range(0, 9) == 0) : 1'b1;
            else
                sda = 1'($urandom_range(0, 1));
            req = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : REQ_TICK;
            push_tick(req, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), sda, 1'b0,
                      '0);
            used++;
            if (!paused_mid && used == 40)
            begin
                paused_mid = 1'b1;
                wait_drained();
            end
        end
    endtask

    initial
    begin : stimulus
        int          spent;
        int          used;
        logic [2:0]  cs;
        logic [15:0] pt;
        logic [7:0]  at;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_TICK;
        mem_address = 8'h00;
        write_data = 8'h00;
        sda_in = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CHIP_SELECT;
        cfg_data = 16'h0000;
        sel_pins = 3'd0;
        hold_ticks = 16'd1;
        poll_limit = ACK_TIMEOUT_RESET;
        seq_pos = 0;
        bit_idx = 0;
        shifter = 8'h00;
        hold_left = 0;
        polls = 8'h00;
        reading = 1'b0;
        addr_q = 8'h00;
        data_q = 8'h00;
        rx_byte = 8'h00;
        scl_q = 1'b1;
        sda_q = 1'b1;
        nack_seen = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // short ack timeout keeps the directed part brief
        write_reg(CFG_ACK_TIMEOUT, PLAN_ACK_TIMEOUT);

        foreach (plan[i])
        begin
            push_tick(plan[i].req, plan[i].addr, plan[i].data, plan[i].sda, plan[i].typed,
                      plan[i].want);
            if (plan[i].run == RUN_TO_IDLE)
            begin
                while (seq_pos != 0)
                    push_tick(REQ_TICK, 8'h00, 8'h00, plan[i].sda, 1'b0, '0);
            end
            else if (plan[i].run == RUN_TO_FINISH)
            begin
                while (!(seq_pos == 1 + (seg_count() - 1) * SUBS + 3 && hold_left == 0))
                    push_tick(REQ_TICK, 8'h00, 8'h00, plan[i].sda, 1'b0, '0);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    cs = 3'd7;
                    pt = 16'd1;
                    at = 8'd1;
                end
                1:
                begin
                    cs = 3'd5;
                    pt = 16'd2;
                    at = 8'd255;
                end
                2:
                begin
                    cs = 3'd0;
                    pt = 16'd0;
                    at = 8'd0;
                end
                3:
                begin
                    cs = 3'd3;
                    pt = 16'd3;
                    at = 8'd7;
                end
                4:
                begin
                    cs = 3'($urandom_range(0, 7));
                    pt = 16'($urandom_range(1, 4));
                    at = 8'($urandom_range(1, 20));
                end
                5:
                begin
                    cs = 3'd2;
                    pt = 16'd1;
                    at = ACK_TIMEOUT_RESET;
                end
                6:
                begin
                    cs = 3'($urandom_range(0, 7));
                    pt = 16'($urandom_range(1, 2));
                    at = 8'($urandom_range(0, 255));
                end
                default:
                begin
                    cs = 3'd1;
                    pt = 16'hFFFF;
                    at = 8'd128;
                end
            endcase
            write_reg(CFG_CHIP_SELECT, {13'd0, cs});
            write_reg(CFG_PHASE_TICKS, pt);
            write_reg(CFG_ACK_TIMEOUT, {8'd0, at});
            if (ph == 0)
                write_reg(CFG_UNMAPPED, 16'($urandom_range(0, 65535)));
            spent = 0;
            while (spent < PHASE_BEATS)
            begin
                run_transfer(PHASE_BEATS - spent, used);
                spent += used;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : receiver
        int run_left;
        bit hold;
        bit long_hold_done;
        run_left = 0;
        hold = 1'b0;
        long_hold_done = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            while (run_left == 0)
            begin
                if (!long_hold_done && beats_checked >= 300)
                begin
                    long_hold_done = 1'b1;
                    hold = 1'b1;
                    run_left = 120;
                end
                else if (hold)
                begin
                    hold = 1'b0;
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                          : $urandom_range(1, 8);
                end
                else
                begin
                    hold = 1'b1;
                    run_left = idle_len();
                end
            end
            run_left--;
            out_stall <= hold;
        end
    end

    always @(posedge clk)
    begin : check_results
        pins_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            beats_checked++;
            if (expected_pins.size() == 0)
                flag_error("result beat with nothing expected");
            else
            begin
                want = expected_pins.pop_front();
                check_field("scl_out", 8'(want.scl), 8'(scl_out));
                check_field("sda_out", 8'(want.sda), 8'(sda_out));
                check_field("busy_res", 8'(want.busy), 8'(busy_res));
                check_field("done_res", 8'(want.done), 8'(done_res));
                check_field("read_data", want.rdata, read_data);
                check_field("ack_missing", 8'(want.nack), 8'(ack_missing));
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
rtl/i2c_eeprom_pkg.sv
rtl/i2c_eeprom_byte_access_master.sv
dv/i2c_eeprom_byte_access_master_test.sv
